@@ sv/vde_pkg.sv @@
// ----------------------------------------------------------------------------
// vde_pkg
// Types, constants and the controller command and status structs shared by
// the vector distance engine modules.
// ----------------------------------------------------------------------------
package vde_pkg;

  localparam int unsigned DefaultMaxDim   = 1024;
  localparam int unsigned DefaultFracBits = 12;
  localparam int unsigned OutFrac         = 24;
  localparam int unsigned AccW            = 48;
  localparam int unsigned AbsW            = 32;
  localparam int unsigned OutW            = 64;
  localparam int unsigned RootW           = 48;

  typedef enum logic [2:0] {
    METRIC_L2SQ  = 3'd0,
    METRIC_L2    = 3'd1,
    METRIC_DOT   = 3'd2,
    METRIC_NDOT  = 3'd3,
    METRIC_COS   = 3'd4,
    METRIC_L1    = 3'd5,
    METRIC_RSVD6 = 3'd6,
    METRIC_RSVD7 = 3'd7
  } metric_t;

  typedef enum logic [3:0] {
    ST_ACC,
    ST_MUL,
    ST_SQRT,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic accumulate;
    logic start_final;
    logic mul_step;
    logic sqrt_init;
    logic sqrt_step;
    logic div_init;
    logic div_step;
    logic load_result;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic sqrt_done;
    logic div_done;
  } status_t;

endpackage

@@ sv/vde_ctrl.sv @@
// ----------------------------------------------------------------------------
// vde_ctrl
// Controller: sequences accumulation, the wide multiply, the square root and
// the cosine division, then presents one result word.
// ----------------------------------------------------------------------------
module vde_ctrl
  import vde_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_fire,
  input  logic    in_last,
  input  metric_t metric,
  input  logic    out_free,
  input  status_t status,
  output logic    in_ready,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_ACC;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_ACC: begin
        in_ready = 1'b1;
        if (in_fire) begin
          cmd.accumulate = 1'b1;
          if (in_last) begin
            cmd.start_final = 1'b1;
            if (metric == METRIC_L2) begin
              state_next = ST_SQRT;
            end else if (metric == METRIC_COS) begin
              state_next = ST_MUL;
            end else begin
              state_next = ST_OUT;
            end
          end
        end
      end
      ST_MUL: begin
        cmd.mul_step = 1'b1;
        if (status.mul_done) begin
          cmd.sqrt_init = 1'b1;
          state_next = ST_SQRT;
        end
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (status.sqrt_done) begin
          if (metric == METRIC_COS) begin
            cmd.div_init = 1'b1;
            state_next = ST_DIV;
          end else begin
            state_next = ST_OUT;
          end
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          cmd.load_result = 1'b1;
          state_next = ST_ACC;
        end
      end
      default: state_next = ST_ACC;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst)
    cmd.load_result |=> state == ST_ACC)
    else $error("load_result not followed by accumulate state");
  assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == ST_ACC)
    else $error("ready outside accumulate state");
  assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> metric == METRIC_COS)
    else $error("divider running for non-cosine metric");

endmodule

@@ sv/vde_dp.sv @@
// ----------------------------------------------------------------------------
// vde_dp
// Datapath: saturating accumulators, a 4-step wide multiplier, a bit-serial
// square root, a restoring divider and the output register.
// ----------------------------------------------------------------------------
module vde_dp
  import vde_pkg::*;
#(
  parameter int unsigned FRAC_BITS = DefaultFracBits
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cmd_t                   cmd,
  input  logic signed [15:0]     a_value,
  input  logic signed [15:0]     b_value,
  input  metric_t                metric,
  input  logic                   out_take,
  output status_t                status,
  output logic                   out_valid,
  output logic        [OutW-1:0] distance
);

  localparam int unsigned Twice = 2 * FRAC_BITS;
  localparam int unsigned ShUp  = (Twice <= OutFrac) ? OutFrac - Twice : 0;
  localparam int unsigned ShDn  = (Twice > OutFrac) ? Twice - OutFrac : 0;
  localparam int unsigned L2Sh  = 2 * OutFrac - Twice;
  localparam int unsigned L1Sh  = OutFrac - FRAC_BITS;
  localparam logic signed [AccW-1:0] AccMax = {1'b0, {(AccW-1){1'b1}}};
  localparam logic signed [AccW-1:0] AccMin = {1'b1, {(AccW-1){1'b0}}};
  localparam logic signed [OutW-1:0] One    = 64'sd1 <<< OutFrac;

  logic signed [AccW-1:0] dot_sum, norm_a_sum, norm_b_sum, sq_diff_sum;
  logic        [AbsW-1:0] abs_diff_sum;
  logic signed [AccW-1:0] dot_f, sq_f, na_f, nb_f;
  logic        [AbsW-1:0] abs_f;

  function automatic logic signed [AccW-1:0] sat_add(
    input logic signed [AccW-1:0] acc,
    input logic signed [32:0]     p
  );
    logic signed [AccW:0] s;
    begin
      s = {acc[AccW-1], acc} + (AccW+1)'(p);
      if (s > (AccW+1)'(AccMax)) begin
        sat_add = AccMax;
      end else if (s < (AccW+1)'(AccMin)) begin
        sat_add = AccMin;
      end else begin
        sat_add = s[AccW-1:0];
      end
    end
  endfunction

  logic signed [16:0] diff;
  logic        [16:0] adiff;
  logic signed [32:0] p_ab, p_aa, p_bb, p_dd;
  logic        [AbsW:0] abs_s;

  assign diff  = 17'(a_value) - 17'(b_value);
  assign adiff = diff[16] ? 17'(-diff) : 17'(diff);
  assign p_ab  = 33'(a_value * b_value);
  assign p_aa  = 33'(a_value * a_value);
  assign p_bb  = 33'(b_value * b_value);
  assign p_dd  = 33'(diff * diff);
  assign abs_s = {1'b0, abs_diff_sum} + (AbsW+1)'(adiff);

  always_ff @(posedge clk) begin
    if (rst) begin
      dot_sum <= '0;
      norm_a_sum <= '0;
      norm_b_sum <= '0;
      sq_diff_sum <= '0;
      abs_diff_sum <= '0;
    end else if (cmd.accumulate) begin
      if (cmd.start_final) begin
        dot_sum <= '0;
        norm_a_sum <= '0;
        norm_b_sum <= '0;
        sq_diff_sum <= '0;
        abs_diff_sum <= '0;
        dot_f <= sat_add(dot_sum, p_ab);
        na_f <= sat_add(norm_a_sum, p_aa);
        nb_f <= sat_add(norm_b_sum, p_bb);
        sq_f <= sat_add(sq_diff_sum, p_dd);
        abs_f <= abs_s[AbsW] ? {AbsW{1'b1}} : abs_s[AbsW-1:0];
      end else begin
        dot_sum <= sat_add(dot_sum, p_ab);
        norm_a_sum <= sat_add(norm_a_sum, p_aa);
        norm_b_sum <= sat_add(norm_b_sum, p_bb);
        sq_diff_sum <= sat_add(sq_diff_sum, p_dd);
        abs_diff_sum <= abs_s[AbsW] ? {AbsW{1'b1}} : abs_s[AbsW-1:0];
      end
    end
  end

  function automatic logic signed [OutW-1:0] to_q24(input logic signed [AccW-1:0] v);
    logic signed [OutW-1:0] w;
    begin
      w = OutW'(v);
      if (Twice <= OutFrac) begin
        to_q24 = w <<< ShUp;
      end else begin
        to_q24 = (w + (64'sd1 <<< (ShDn - 1))) >>> ShDn;
      end
    end
  endfunction

  // Norm product: 48x48 unsigned as four 24x24 partial products.
  logic [95:0] prod;
  logic [2:0]  mphase;
  logic [23:0] mx, my;
  logic [47:0] pp;
  logic [6:0]  pshift;

  always_comb begin
    mx     = mphase[1] ? na_f[47:24] : na_f[23:0];
    my     = mphase[0] ? nb_f[47:24] : nb_f[23:0];
    pp     = mx * my;
    pshift = (mphase[1] ? 7'd24 : 7'd0) + (mphase[0] ? 7'd24 : 7'd0);
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.start_final) begin
      mphase <= '0;
      prod   <= '0;
    end else if (cmd.mul_step && !status.mul_done) begin
      mphase <= mphase + 3'd1;
      prod   <= prod + (96'(pp) << pshift);
    end
  end
  assign status.mul_done = (mphase == 3'd4);

  // Bit-serial square root, one result bit per cycle, of a value below 2^96.
  logic [95:0]  rad;
  logic [97:0]  srem;
  logic [RootW-1:0] root;
  logic [5:0]   scnt;
  logic [97:0]  trial;

  assign trial = {srem[95:0], rad[95:94]} - {48'd0, root, 2'b01};

  logic [95:0] l2_rad;
  assign l2_rad = 96'(sat_add(sq_diff_sum, p_dd)) << L2Sh;

  always_ff @(posedge clk) begin
    if (cmd.start_final) begin
      rad  <= l2_rad;
      srem <= '0;
      root <= '0;
      scnt <= '0;
    end else if (cmd.sqrt_init) begin
      rad  <= prod;
      srem <= '0;
      root <= '0;
      scnt <= '0;
    end else if (cmd.sqrt_step && scnt != 6'(RootW)) begin
      rad  <= {rad[93:0], 2'b00};
      scnt <= scnt + 6'd1;
      if (!trial[97]) begin
        srem <= trial;
        root <= {root[RootW-2:0], 1'b1};
      end else begin
        srem <= {srem[95:0], rad[95:94]};
        root <= {root[RootW-2:0], 1'b0};
      end
    end
  end
  assign status.sqrt_done = (scnt == 6'(RootW));

  // Restoring division of |dot| by the root, OutFrac quotient bits.
  logic [AccW:0]  drem;
  logic [OutFrac:0] quo;
  logic [4:0]     dcnt;
  logic [AccW:0]  dsh;
  logic [AccW-1:0] mag;
  logic           dneg;

  assign mag = dot_f[AccW-1] ? AccW'(-dot_f) : AccW'(dot_f);
  assign dsh = {drem[AccW-1:0], 1'b0};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      drem <= (AccW+1)'(mag);
      quo  <= '0;
      dcnt <= '0;
      dneg <= dot_f[AccW-1];
    end else if (cmd.div_step && dcnt != 5'(OutFrac)) begin
      dcnt <= dcnt + 5'd1;
      if (dsh >= (AccW+1)'(root)) begin
        drem <= dsh - (AccW+1)'(root);
        quo  <= {quo[OutFrac-1:0], 1'b1};
      end else begin
        drem <= dsh;
        quo  <= {quo[OutFrac-1:0], 1'b0};
      end
    end
  end
  assign status.div_done = (dcnt == 5'(OutFrac));

  logic signed [OutW-1:0] sim, cos_q, res;
  always_comb begin
    if ((AccW+1)'(mag) >= (AccW+1)'(root)) begin
      sim = One;
    end else begin
      sim = OutW'(quo);
    end
    if (dneg) begin
      sim = -sim;
    end
    cos_q = (root == '0) ? One : One - sim;
    case (metric)
      METRIC_L2SQ: res = to_q24(sq_f);
      METRIC_L2:   res = OutW'(root);
      METRIC_DOT:  res = to_q24(dot_f);
      METRIC_NDOT: res = -to_q24(dot_f);
      METRIC_COS:  res = cos_q;
      METRIC_L1:   res = OutW'(abs_f) << L1Sh;
      default:     res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_result) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      distance <= res;
    end
  end

endmodule

@@ sv/vector_distance_engine.sv @@
// ----------------------------------------------------------------------------
// vector_distance_engine
// Streams element pairs and returns one metric word per vector.
// ----------------------------------------------------------------------------
// One element pair is accepted per cycle while a vector streams in. After the
// pair marked last the engine stops taking words until the result is loaded:
// squared L2, dot, negated dot, L1 and unused codes go straight to output;
// L2 runs the 48-step square root; cosine runs the 4-step norm multiply,
// the 48-step square root and the 24-step divider. A result in the output
// register blocks loading of the next one, and no pairs are taken meanwhile.
module vector_distance_engine
  import vde_pkg::*;
#(
  parameter int unsigned FRAC_BITS = DefaultFracBits
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // a_value[15:0], b_value[31:16]
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // distance[63:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_data
);

  metric_t metric;
  cmd_t    cmd;
  status_t status;
  logic    in_fire;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      metric <= METRIC_L2SQ;
    end else if (cfg_valid) begin
      metric <= metric_t'(cfg_data);
    end
  end

  assign in_fire = s_tvalid && s_tready;

  vde_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_fire),
    .in_last  (s_tlast),
    .metric   (metric),
    .out_free (!m_tvalid || m_tready),
    .status   (status),
    .in_ready (s_tready),
    .cmd      (cmd)
  );

  vde_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .a_value   (s_tdata[15:0]),
    .b_value   (s_tdata[31:16]),
    .metric    (metric),
    .out_take  (m_tready),
    .status    (status),
    .out_valid (m_tvalid),
    .distance  (m_tdata)
  );

endmodule
